// ===== hw/rtl/rsa_pkg.sv =====
// Shared constants, codes and controller/datapath command and status types.
package rsa_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int DATA_W      = 16;
    localparam int DEPTH_W     = 4;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_RAW_W    = $clog2(STACK_DEPTH + 1);
    localparam int SP_W        = (SP_RAW_W > DEPTH_W) ? SP_RAW_W : DEPTH_W;
    localparam int CNT_W       = $clog2(DATA_W);

    // operation field
    localparam logic [1:0] OPN_PUSH  = 2'd0;
    localparam logic [1:0] OPN_POP   = 2'd1;
    localparam logic [1:0] OPN_APPLY = 2'd2;

    // operator_code field
    localparam logic [4:0] OPR_NOT  = 5'd0;
    localparam logic [4:0] OPR_ABS  = 5'd1;
    localparam logic [4:0] OPR_DIV  = 5'd2;
    localparam logic [4:0] OPR_MUL  = 5'd3;
    localparam logic [4:0] OPR_ADD  = 5'd4;
    localparam logic [4:0] OPR_SUB  = 5'd5;
    localparam logic [4:0] OPR_MOD  = 5'd6;
    localparam logic [4:0] OPR_AND  = 5'd7;
    localparam logic [4:0] OPR_OR   = 5'd8;
    localparam logic [4:0] OPR_XOR  = 5'd9;
    localparam logic [4:0] OPR_EQ   = 5'd10;
    localparam logic [4:0] OPR_NE   = 5'd11;
    localparam logic [4:0] OPR_LT   = 5'd12;
    localparam logic [4:0] OPR_LTE  = 5'd13;
    localparam logic [4:0] OPR_GT   = 5'd14;
    localparam logic [4:0] OPR_GTE  = 5'd15;
    localparam logic [4:0] OPR_LAND = 5'd16;
    localparam logic [4:0] OPR_LOR  = 5'd17;
    localparam logic [4:0] OPR_MIN  = 5'd18;
    localparam logic [4:0] OPR_MAX  = 5'd19;

    typedef enum logic [2:0] {
        KIND_PUSH,
        KIND_POP,
        KIND_UNARY,
        KIND_BINARY,
        KIND_DIVIDE,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        logic latch;     // capture the input item
        logic push;      // push the latched value
        logic pop;       // pop into the result, fetch the entry below
        logic take_b;    // first operand from the top, fetch the entry below
        logic take_a;    // second operand from the fetched entry, load divider
        logic div_step;  // one quotient bit
        logic load_top;  // refresh the cached top after a pop
        logic exec;      // write the operator result back
        logic out_load;  // load the output register
    } cmd_t;

    typedef struct packed {
        kind_t           kind;
        logic            div_last;
        logic [SP_W-1:0] sp;
    } sts_t;

endpackage

// ===== hw/rtl/rsa_if.sv =====
// Valid/ready channels for input items and result items.
interface rsa_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       operation;
    logic signed [rsa_pkg::DATA_W-1:0] push_value;
    logic [4:0]                       operator_code;

    modport source (output valid, output operation, output push_value,
                    output operator_code, input ready);
    modport sink   (input valid, input operation, input push_value,
                    input operator_code, output ready);
endinterface

interface rsa_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rsa_pkg::DATA_W-1:0]  result_value;
    logic [rsa_pkg::DEPTH_W-1:0]        stack_depth;

    modport source (output valid, output result_value, output stack_depth,
                    input ready);
    modport sink   (input valid, input result_value, input stack_depth,
                    output ready);
endinterface

// ===== hw/rtl/rsa_ctrl.sv =====
// Sequencing state machine for the stack ALU.
module rsa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rsa_pkg::sts_t     sts,
    output rsa_pkg::cmd_t     cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DECODE    = 7'b0000010,
        ST_FETCH_A   = 7'b0000100,
        ST_FETCH_TOP = 7'b0001000,
        ST_DIV       = 7'b0010000,
        ST_EXEC      = 7'b0100000,
        ST_DONE      = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.kind)
                    rsa_pkg::KIND_PUSH:
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_DONE;
                    end
                    rsa_pkg::KIND_POP:
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ST_FETCH_TOP;
                    end
                    rsa_pkg::KIND_UNARY:
                    begin
                        cmd.take_b = 1'b1;
                        state_next = ST_EXEC;
                    end
                    rsa_pkg::KIND_BINARY, rsa_pkg::KIND_DIVIDE:
                    begin
                        cmd.take_b = 1'b1;
                        state_next = ST_FETCH_A;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_FETCH_A:
            begin
                cmd.take_a = 1'b1;
                state_next = (sts.kind == rsa_pkg::KIND_DIVIDE) ? ST_DIV : ST_EXEC;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_FETCH_TOP:
            begin
                cmd.load_top = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/rsa_dpath.sv =====
// Stack memory, cached top, operand registers, ALU and serial divider.
module rsa_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [1:0]                          operation,
    input  logic signed [rsa_pkg::DATA_W-1:0]   push_value,
    input  logic [4:0]                          operator_code,
    input  rsa_pkg::cmd_t                       cmd,
    output rsa_pkg::sts_t                       sts,
    output logic signed [rsa_pkg::DATA_W-1:0]   result_value,
    output logic [rsa_pkg::DEPTH_W-1:0]         stack_depth
);

    localparam int DW = rsa_pkg::DATA_W;
    localparam int SW = rsa_pkg::SP_W;
    localparam int IW = rsa_pkg::IDX_W;
    localparam int CW = rsa_pkg::CNT_W;

    logic [DW-1:0] mem [rsa_pkg::STACK_DEPTH];
    logic [DW-1:0] rd_data_reg;

    logic [1:0]    opn_reg;
    logic [DW-1:0] val_reg;
    logic [4:0]    code_reg;
    logic [SW-1:0] sp_reg, sp_next;
    logic [DW-1:0] top_reg, pop_val_reg, a_reg, b_reg;
    logic [DW-1:0] out_val_reg;
    logic [rsa_pkg::DEPTH_W-1:0] out_depth_reg;

    logic [DW-1:0] dvd_reg, rem_reg, dvs_reg;
    logic [CW-1:0] cnt_reg;

    logic          sp_zero, sp_ge2, sp_full, is_unary;
    logic [SW-1:0] sp_m1, sp_m2, base;
    logic [DW-1:0] top_or_zero, a_next, alu_res;
    logic [DW-1:0] q_mag, q_signed, r_signed;
    logic [DW:0]   partial, diff;
    logic [2*DW-1:0] prod;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [DW-1:0] mem_wd;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
        mag = x[DW-1] ? DW'(-x) : x;
    endfunction

    function automatic logic [DW-1:0] flag(input logic c);
        flag = {{(DW-1){1'b0}}, c};
    endfunction

    // item classification
    always_comb
    begin
        sts.kind = rsa_pkg::KIND_NOP;
        case (opn_reg)
            rsa_pkg::OPN_PUSH:  sts.kind = rsa_pkg::KIND_PUSH;
            rsa_pkg::OPN_POP:   sts.kind = rsa_pkg::KIND_POP;
            rsa_pkg::OPN_APPLY:
            begin
                if (code_reg inside {rsa_pkg::OPR_NOT, rsa_pkg::OPR_ABS})
                    sts.kind = rsa_pkg::KIND_UNARY;
                else if (code_reg inside {rsa_pkg::OPR_DIV, rsa_pkg::OPR_MOD})
                    sts.kind = rsa_pkg::KIND_DIVIDE;
                else if (code_reg inside {[rsa_pkg::OPR_MUL : rsa_pkg::OPR_MAX]})
                    sts.kind = rsa_pkg::KIND_BINARY;
                else
                    sts.kind = rsa_pkg::KIND_NOP;
            end
            default:            sts.kind = rsa_pkg::KIND_NOP;
        endcase
    end

    assign sts.div_last = (cnt_reg == CW'(DW - 1));
    assign sts.sp       = sp_reg;

    assign sp_zero     = (sp_reg == '0);
    assign sp_ge2      = (sp_reg >= SW'(2));
    assign sp_full     = (sp_reg >= SW'(rsa_pkg::STACK_DEPTH));
    assign sp_m1       = sp_reg - SW'(1);
    assign sp_m2       = sp_reg - SW'(2);
    assign top_or_zero = sp_zero ? '0 : top_reg;
    assign a_next      = sp_ge2 ? rd_data_reg : '0;
    assign is_unary    = (code_reg == rsa_pkg::OPR_NOT) || (code_reg == rsa_pkg::OPR_ABS);
    // empty slots on a short stack count as zero operands
    assign base        = is_unary ? (sp_zero ? '0 : sp_m1) : (sp_ge2 ? sp_m2 : '0);

    // divider result fix-up
    assign q_mag    = dvd_reg;
    assign q_signed = (a_reg[DW-1] ^ b_reg[DW-1]) ? DW'(-q_mag) : q_mag;
    assign r_signed = a_reg[DW-1] ? DW'(-rem_reg) : rem_reg;
    assign partial  = {rem_reg, dvd_reg[DW-1]};
    assign diff     = partial - {1'b0, dvs_reg};

    assign prod = {{DW{a_reg[DW-1]}}, a_reg} * {{DW{b_reg[DW-1]}}, b_reg};

    always_comb
    begin
        case (code_reg)
            rsa_pkg::OPR_NOT:  alu_res = ~a_reg;
            rsa_pkg::OPR_ABS:  alu_res = mag(a_reg);
            rsa_pkg::OPR_DIV:  alu_res = (b_reg == '0) ? '0 : q_signed;
            rsa_pkg::OPR_MUL:  alu_res = prod[DW-1:0];
            rsa_pkg::OPR_ADD:  alu_res = a_reg + b_reg;
            rsa_pkg::OPR_SUB:  alu_res = a_reg - b_reg;
            rsa_pkg::OPR_MOD:  alu_res = (b_reg == '0) ? '0 : r_signed;
            rsa_pkg::OPR_AND:  alu_res = a_reg & b_reg;
            rsa_pkg::OPR_OR:   alu_res = a_reg | b_reg;
            rsa_pkg::OPR_XOR:  alu_res = a_reg ^ b_reg;
            rsa_pkg::OPR_EQ:   alu_res = flag(a_reg == b_reg);
            rsa_pkg::OPR_NE:   alu_res = flag(a_reg != b_reg);
            rsa_pkg::OPR_LT:   alu_res = flag($signed(a_reg) <  $signed(b_reg));
            rsa_pkg::OPR_LTE:  alu_res = flag($signed(a_reg) <= $signed(b_reg));
            rsa_pkg::OPR_GT:   alu_res = flag($signed(a_reg) >  $signed(b_reg));
            rsa_pkg::OPR_GTE:  alu_res = flag($signed(a_reg) >= $signed(b_reg));
            rsa_pkg::OPR_LAND: alu_res = flag((a_reg != '0) && (b_reg != '0));
            rsa_pkg::OPR_LOR:  alu_res = flag((a_reg != '0) || (b_reg != '0));
            rsa_pkg::OPR_MIN:  alu_res = ($signed(a_reg) < $signed(b_reg)) ? a_reg : b_reg;
            rsa_pkg::OPR_MAX:  alu_res = ($signed(a_reg) > $signed(b_reg)) ? a_reg : b_reg;
            default:           alu_res = a_reg;
        endcase
    end

    // memory port control
    always_comb
    begin
        mem_we  = 1'b0;
        mem_wa  = sp_reg[IW-1:0];
        mem_wd  = val_reg;
        if (cmd.push && !sp_full)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.exec)
        begin
            mem_we = 1'b1;
            mem_wa = base[IW-1:0];
            mem_wd = alu_res;
        end
        rd_en   = cmd.pop || cmd.take_b;
        rd_addr = sp_m2[IW-1:0];
    end

    always_comb
    begin
        sp_next = sp_reg;
        if (cmd.push && !sp_full)
            sp_next = sp_reg + SW'(1);
        else if (cmd.pop && !sp_zero)
            sp_next = sp_m1;
        else if (cmd.exec)
            sp_next = base + SW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_reg <= '0;
        else
            sp_reg <= sp_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            opn_reg  <= operation;
            val_reg  <= push_value;
            code_reg <= operator_code;
        end
        if (cmd.push && !sp_full)
            top_reg <= val_reg;
        if (cmd.pop)
            pop_val_reg <= top_or_zero;
        if (cmd.load_top && !sp_zero)
            top_reg <= rd_data_reg;
        if (cmd.exec)
            top_reg <= alu_res;
        if (cmd.take_b)
        begin
            b_reg <= top_or_zero;
            a_reg <= top_or_zero;
        end
        if (cmd.take_a)
        begin
            a_reg   <= a_next;
            dvd_reg <= mag(a_next);
            dvs_reg <= mag(b_reg);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (!diff[DW])
            begin
                rem_reg <= diff[DW-1:0];
                dvd_reg <= {dvd_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= partial[DW-1:0];
                dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            out_val_reg   <= (opn_reg == rsa_pkg::OPN_POP) ? pop_val_reg : top_or_zero;
            out_depth_reg <= sp_reg[rsa_pkg::DEPTH_W-1:0];
        end
    end

    assign result_value = out_val_reg;
    assign stack_depth  = out_depth_reg;

endmodule

// ===== hw/rtl/rpn_stack_alu.sv =====
// Top level: reverse-Polish 16-bit stack ALU, controller plus datapath.
// The serial divider produces one quotient bit per cycle. Flow: one item in flight; the
// next item is taken once the result sits in the output register, so a stalled result
// does not hold up the following item's input.
// Reset: rst_n asynchronous, clears the stack pointer and all handshake state; stack
// memory contents are left as they are and are never used before being written.
module rpn_stack_alu (
    input  logic       clk,
    input  logic       rst_n,
    rsa_in_if.sink     in_ch,
    rsa_out_if.source  out_ch
);

    rsa_pkg::cmd_t cmd;
    rsa_pkg::sts_t sts;

    // Controller: walks each item through decode, operand fetch, divide, write-back
    // and output hand-off.
    rsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: stack memory with a cached top, operand registers, ALU, divider
    // and the output register.
    rsa_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (in_ch.operation),
        .push_value    (in_ch.push_value),
        .operator_code (in_ch.operator_code),
        .cmd           (cmd),
        .sts           (sts),
        .result_value  (out_ch.result_value),
        .stack_depth   (out_ch.stack_depth)
    );

    // The stack pointer never runs past the stack size.
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sts.sp <= rsa_pkg::SP_W'(rsa_pkg::STACK_DEPTH))
        else $error("stack pointer beyond stack size");

    // Only one item is in flight: an accepted item drops ready.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("item accepted while another is in flight");

    // Stack-changing commands are mutually exclusive.
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.push, cmd.pop, cmd.take_b, cmd.take_a, cmd.load_top, cmd.exec}))
        else $error("conflicting datapath commands");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_ch.valid || out_ch.ready))
        else $error("output register overwritten");

endmodule

// ===== tb/tb_rpn_stack_alu.sv =====
// Self-checking testbench for the reverse-Polish stack ALU, with its own stack model.
module tb_rpn_stack_alu;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = rsa_pkg::DATA_W;

    // codes the package leaves unnamed: the spare operation and the undefined operators
    localparam logic [1:0] OPN_SPARE     = 2'd3;
    localparam logic [4:0] OPR_UNDEF_LOW = 5'd20;
    localparam logic [4:0] OPR_UNDEF_TOP = 5'd31;

    localparam int RANDOM_ITEMS = 925;
    localparam int IDLE_PCT     = 28;
    // items accepted while both sides run flat out
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 450;
    // long output hold-off once this many items are in
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 150;
    // divide is the slowest item
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [1:0]                operation;
        logic signed [DW-1:0]      push_value;
        logic [4:0]                operator_code;
    } stack_item_t;

    typedef struct {
        logic signed [DW-1:0]              value;
        logic [rsa_pkg::DEPTH_W-1:0]       depth;
    } stack_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // everything the testbench drives starts at a known value
    logic                      drv_valid = 1'b0;
    logic [1:0]                drv_operation = rsa_pkg::OPN_PUSH;
    logic signed [DW-1:0]      drv_push_value = '0;
    logic [4:0]                drv_operator_code = rsa_pkg::OPR_NOT;
    logic                      drv_ready = 1'b0;

    rsa_in_if  in_ch ();
    rsa_out_if out_ch ();

    assign in_ch.valid         = drv_valid;
    assign in_ch.operation     = drv_operation;
    assign in_ch.push_value    = drv_push_value;
    assign in_ch.operator_code = drv_operator_code;
    assign out_ch.ready        = drv_ready;

    rpn_stack_alu u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #2 clk = ~clk;

    stack_item_t   pending_items[$];
    stack_result_t expected_results[$];
    int            total_items = 0;
    int            items_accepted = 0;
    int            error_count = 0;

    // ------------------------------------------------------------------
    // Stack model: shadow copy of the entries and the pointer
    // ------------------------------------------------------------------
    logic signed [DW-1:0]     shadow_stack [rsa_pkg::STACK_DEPTH];
    int unsigned              shadow_sp = 0;

    // a push to a full stack is simply lost
    function automatic void shadow_push(logic signed [DW-1:0] v);
        if (shadow_sp < rsa_pkg::STACK_DEPTH)
        begin
            shadow_stack[shadow_sp] = v;
            shadow_sp++;
        end
    endfunction

    // an empty stack yields 0 and stays empty
    function automatic logic signed [DW-1:0] shadow_pop();
        if (shadow_sp == 0)
            return '0;
        shadow_sp--;
        return shadow_stack[shadow_sp];
    endfunction

    function automatic logic signed [DW-1:0] shadow_top();
        if (shadow_sp == 0)
            return '0;
        return shadow_stack[shadow_sp - 1];
    endfunction

    // Operands are widened to int so the overflow cases (-32768 / -1,
    // abs(-32768), mul) come out right once cut back to 16 bits.
    function automatic void apply_operator(logic [4:0] code);
        int a;
        int b;
        int r;
        if (code > rsa_pkg::OPR_MAX)
            return;
        if (code == rsa_pkg::OPR_NOT || code == rsa_pkg::OPR_ABS)
        begin
            a = shadow_pop();
            r = (code == rsa_pkg::OPR_NOT) ? ~a : ((a < 0) ? -a : a);
            shadow_push(r[DW-1:0]);
            return;
        end
        // b comes off first, then a
        b = shadow_pop();
        a = shadow_pop();
        case (code)
            rsa_pkg::OPR_DIV:  r = (b != 0) ? a / b : 0;
            rsa_pkg::OPR_MUL:  r = a * b;
            rsa_pkg::OPR_ADD:  r = a + b;
            rsa_pkg::OPR_SUB:  r = a - b;
            rsa_pkg::OPR_MOD:  r = (b != 0) ? a % b : 0;
            rsa_pkg::OPR_AND:  r = a & b;
            rsa_pkg::OPR_OR:   r = a | b;
            rsa_pkg::OPR_XOR:  r = a ^ b;
            rsa_pkg::OPR_EQ:   r = int'(a == b);
            rsa_pkg::OPR_NE:   r = int'(a != b);
            rsa_pkg::OPR_LT:   r = int'(a < b);
            rsa_pkg::OPR_LTE:  r = int'(a <= b);
            rsa_pkg::OPR_GT:   r = int'(a > b);
            rsa_pkg::OPR_GTE:  r = int'(a >= b);
            rsa_pkg::OPR_LAND: r = int'(a != 0 && b != 0);
            rsa_pkg::OPR_LOR:  r = int'(a != 0 || b != 0);
            rsa_pkg::OPR_MIN:  r = (a < b) ? a : b;
            default:           r = (a > b) ? a : b;
        endcase
        shadow_push(r[DW-1:0]);
    endfunction

    // one item in, one result out
    function automatic stack_result_t stack_eval(stack_item_t it);
        stack_result_t res;
        case (it.operation)
            rsa_pkg::OPN_PUSH:
            begin
                shadow_push(it.push_value);
                res.value = shadow_top();
            end
            rsa_pkg::OPN_POP:
                res.value = shadow_pop();
            rsa_pkg::OPN_APPLY:
            begin
                apply_operator(it.operator_code);
                res.value = shadow_top();
            end
            default:
                res.value = shadow_top();
        endcase
        res.depth = shadow_sp[rsa_pkg::DEPTH_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic void queue_item(logic [1:0] op, logic signed [DW-1:0] v,
                                       logic [4:0] code);
        stack_item_t it;
        it.operation     = op;
        it.push_value    = v;
        it.operator_code = code;
        pending_items.push_back(it);
    endfunction

    // Mostly pushes and defined operators so the stack wanders between empty
    // and full; small values make equality and divide results interesting.
    function automatic stack_item_t random_item();
        stack_item_t it;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            it.operation = rsa_pkg::OPN_PUSH;
        else if (pick < 80)
            it.operation = rsa_pkg::OPN_APPLY;
        else if (pick < 96)
            it.operation = rsa_pkg::OPN_POP;
        else
            it.operation = OPN_SPARE;

        case ($urandom_range(0, 9))
            0:       it.push_value = 16'sh8000;
            1:       it.push_value = 16'sh7FFF;
            2:       it.push_value = -16'sd1;
            3, 4, 5: it.push_value = DW'($urandom_range(0, 40) - 20);
            default: it.push_value = DW'($urandom);
        endcase

        if ($urandom_range(0, 99) < 92)
            it.operator_code = 5'($urandom_range(rsa_pkg::OPR_NOT, rsa_pkg::OPR_MAX));
        else
            it.operator_code = 5'($urandom_range(OPR_UNDEF_LOW, OPR_UNDEF_TOP));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: changes on the falling edge, one item shown at a time
    // ------------------------------------------------------------------
    int          items_offered = 0;
    stack_item_t next_item;
    logic        calm;

    assign calm = (items_accepted >= CALM_FROM) && (items_accepted < CALM_TO);

    always @(negedge clk)
    begin
        if (!rst_n)
            drv_valid <= 1'b0;
        else if (drv_valid && items_accepted != items_offered)
            ; // item still waiting for ready, hold it
        else if (pending_items.size() != 0 &&
                 (calm || $urandom_range(0, 99) >= IDLE_PCT))
        begin
            next_item = pending_items.pop_front();
            drv_operation     <= next_item.operation;
            drv_push_value    <= next_item.push_value;
            drv_operator_code <= next_item.operator_code;
            drv_valid         <= 1'b1;
            items_offered++;
        end
        else
            drv_valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Output ready: random stalls plus one long hold-off, during which the
    // driver keeps offering so the block backs up and drops its input ready
    // ------------------------------------------------------------------
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
            drv_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            drv_ready <= 1'b0;
        end
        else if (!hold_done && items_accepted >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            drv_ready <= 1'b0;
        end
        else
            drv_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, check results and predict accepted items
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        stack_item_t   seen_item;
        stack_result_t want;
        if (rst_n)
        begin
            // a result can never belong to an item taken on this same edge
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing outstanding: value %0d depth %0d",
                           $signed(out_ch.result_value), out_ch.stack_depth);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.result_value !== want.value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               $signed(want.value), $signed(out_ch.result_value));
                        error_count++;
                    end
                    if (out_ch.stack_depth !== want.depth)
                    begin
                        $error("stack_depth: expected %0d, got %0d",
                               want.depth, out_ch.stack_depth);
                        error_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                seen_item.operation     = in_ch.operation;
                seen_item.push_value    = in_ch.push_value;
                seen_item.operator_code = in_ch.operator_code;
                expected_results.push_back(stack_eval(seen_item));
                items_accepted <= items_accepted + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed items, random items, reset, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        // empty-stack corners: pop, spare operation, operator on nothing
        queue_item(rsa_pkg::OPN_POP,   16'sd0, rsa_pkg::OPR_NOT);
        queue_item(OPN_SPARE,          16'sd0, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_APPLY, 16'sd0, rsa_pkg::OPR_ADD);
        queue_item(rsa_pkg::OPN_APPLY, 16'sd0, OPR_UNDEF_TOP);
        queue_item(rsa_pkg::OPN_POP,   16'sd0, rsa_pkg::OPR_NOT);
        // most negative over minus one, both divide and modulo
        queue_item(rsa_pkg::OPN_PUSH,  16'sh8000, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_PUSH,  -16'sd1, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_APPLY, 16'sd0, rsa_pkg::OPR_DIV);
        queue_item(rsa_pkg::OPN_PUSH,  -16'sd1, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_APPLY, 16'sd0, rsa_pkg::OPR_MOD);
        // divide by zero
        queue_item(rsa_pkg::OPN_PUSH,  16'sd0, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_APPLY, 16'sd0, rsa_pkg::OPR_DIV);
        // abs of the most negative value, then invert it
        queue_item(rsa_pkg::OPN_PUSH,  16'sh8000, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_APPLY, 16'sd0, rsa_pkg::OPR_ABS);
        queue_item(rsa_pkg::OPN_APPLY, 16'sd0, rsa_pkg::OPR_NOT);
        // fill to the top, the last push is dropped
        queue_item(rsa_pkg::OPN_PUSH,  16'sh7FFF, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_PUSH,  16'sh8000, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_PUSH,  16'sh5555, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_PUSH,  16'shAAAA, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_PUSH,  16'sh7FFF, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_PUSH,  -16'sd1, rsa_pkg::OPR_NOT);
        queue_item(rsa_pkg::OPN_PUSH,  16'sh1234, rsa_pkg::OPR_NOT);
        // wrapping arithmetic on the full stack
        queue_item(rsa_pkg::OPN_APPLY, 16'sd0, rsa_pkg::OPR_MUL);
        queue_item(rsa_pkg::OPN_APPLY, 16'sd0, rsa_pkg::OPR_ADD);
        queue_item(rsa_pkg::OPN_APPLY, 16'sd0, rsa_pkg::OPR_SUB);

        repeat (RANDOM_ITEMS)
            pending_items.push_back(random_item());
        total_items = pending_items.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_accepted != total_items)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        // anything arriving now is a stray result
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[rpn_stack_alu] OK");
        else
            $display("[rpn_stack_alu] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("[rpn_stack_alu] ERROR");
        $finish;
    end

endmodule
